@@ src/zdsr_pkg.sv @@
`timescale 1ns / 1ps
package zdsr_pkg;

    localparam logic [7:0]  ZDLE_CODE  = 8'h18;
    localparam logic [7:0]  ESC_XOR    = 8'h40;
    localparam logic [7:0]  END_FIRST  = 8'h68;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    localparam int TOKEN_DEPTH  = 2;
    localparam int RESULT_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        END_ZCRCE = 2'd0,
        END_ZCRCG = 2'd1,
        END_ZCRCQ = 2'd2,
        END_ZCRCW = 2'd3
    } t_end;

    typedef struct packed {
        logic       restart;
        logic       is_byte;
        logic       is_end;
        logic [7:0] value;
    } t_token;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        t_end       end_type;
        logic       ack_wanted;
        logic       frame_over;
    } t_result;

    function automatic logic [31:0] crc_add(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ src/zdata_subpacket_receiver.sv @@
`timescale 1ns / 1ps
// An accepted item is unescaped and written into the token queue; the CRC stage then
// moves its result into the result queue, whose head drives the outputs.
// Throughput: one item per cycle while neither queue is full; the token queue and result
// queue decouple the unescape stage from the CRC stage and the consumer.
// Reset: synchronous active low; clears both queues and the escape flag, presets the CRC.
module zdata_subpacket_receiver #(
    parameter int TOKEN_DEPTH  = zdsr_pkg::TOKEN_DEPTH,
    parameter int RESULT_DEPTH = zdsr_pkg::RESULT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    input  logic       i_restart,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_end_type,
    output logic       o_ack_wanted,
    output logic       o_frame_over
);

    localparam int TOK_W = $bits(zdsr_pkg::t_token);
    localparam int RES_W = $bits(zdsr_pkg::t_result);

    logic              tok_push;
    zdsr_pkg::t_token  tok_in;
    zdsr_pkg::t_token  tok_out;
    logic              tok_empty;
    logic              tok_pop;
    logic              res_push;
    logic              res_full;
    zdsr_pkg::t_result res_in;
    zdsr_pkg::t_result res_out;

    zdsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_rx_byte  (i_rx_byte),
        .i_restart  (i_restart),
        .o_tok_push (tok_push),
        .o_tok      (tok_in)
    );

    zdsr_queue #(
        .WIDTH (TOK_W),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_empty (tok_empty),
        .o_data  (tok_out)
    );

    zdsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (tok_out),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    zdsr_queue #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_kind       = res_out.kind;
    assign o_data_byte  = res_out.data_byte;
    assign o_end_type   = res_out.end_type;
    assign o_ack_wanted = res_out.ack_wanted;
    assign o_frame_over = res_out.frame_over;

endmodule

@@ src/zdsr_queue.sv @@
`timescale 1ns / 1ps
module zdsr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = zdsr_pkg::TOKEN_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ src/zdsr_front.sv @@
`timescale 1ns / 1ps
module zdsr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_restart,
    output logic             o_tok_push,
    output zdsr_pkg::t_token o_tok
);

    logic r_escape, n_escape;
    logic escaped;
    logic is_zdle;

    assign escaped = r_escape && !i_restart;
    assign is_zdle = (i_rx_byte == zdsr_pkg::ZDLE_CODE);

    always_comb begin
        o_tok.restart = i_restart;
        o_tok.is_byte = !is_zdle;
        o_tok.is_end  = escaped && (i_rx_byte[7:2] == zdsr_pkg::END_FIRST[7:2]);
        o_tok.value   = escaped ? (i_rx_byte ^ zdsr_pkg::ESC_XOR) : i_rx_byte;
        o_tok_push    = i_accept && (!is_zdle || i_restart);
        n_escape      = r_escape;
        if (i_accept) begin
            n_escape = is_zdle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 1'b0;
        end else begin
            r_escape <= n_escape;
        end
    end

endmodule

@@ src/zdsr_back.sv @@
`timescale 1ns / 1ps
module zdsr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  zdsr_pkg::t_token  i_tok,
    output logic              o_tok_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output zdsr_pkg::t_result o_res
);

    logic [31:0]     r_crc, n_crc;
    logic            r_in_crc, n_in_crc;
    logic [1:0]      r_cnt, n_cnt;
    logic [31:0]     r_rx_crc, n_rx_crc;
    zdsr_pkg::t_end  r_end, n_end;

    logic [31:0]     crc_c;
    logic            phase_c;
    logic [1:0]      cnt_c;
    logic [31:0]     rx_c;
    zdsr_pkg::t_end  end_c;
    logic [31:0]     rx_full;

    assign o_tok_pop = i_tok_valid && !i_res_full;

    always_comb begin
        crc_c   = i_tok.restart ? zdsr_pkg::CRC_PRESET : r_crc;
        phase_c = i_tok.restart ? 1'b0 : r_in_crc;
        cnt_c   = i_tok.restart ? 2'd0 : r_cnt;
        rx_c    = i_tok.restart ? 32'd0 : r_rx_crc;
        end_c   = i_tok.restart ? zdsr_pkg::END_ZCRCE : r_end;
        rx_full = {i_tok.value, rx_c[31:8]};

        n_crc    = r_crc;
        n_in_crc = r_in_crc;
        n_cnt    = r_cnt;
        n_rx_crc = r_rx_crc;
        n_end    = r_end;

        o_res_push       = 1'b0;
        o_res.kind       = zdsr_pkg::KIND_DATA;
        o_res.data_byte  = i_tok.value;
        o_res.end_type   = zdsr_pkg::END_ZCRCE;
        o_res.ack_wanted = 1'b0;
        o_res.frame_over = 1'b0;

        if (o_tok_pop) begin
            n_crc    = crc_c;
            n_in_crc = phase_c;
            n_cnt    = cnt_c;
            n_rx_crc = rx_c;
            n_end    = end_c;
            if (i_tok.is_byte) begin
                if (phase_c) begin
                    n_rx_crc = rx_full;
                    if (cnt_c != 2'd3) begin
                        n_cnt = cnt_c + 2'd1;
                    end else begin
                        // verdict, then preset for the next subpacket
                        o_res_push       = 1'b1;
                        o_res.kind       = (rx_full == ~crc_c) ? zdsr_pkg::KIND_GOOD
                                                               : zdsr_pkg::KIND_BAD;
                        o_res.data_byte  = 8'd0;
                        o_res.end_type   = end_c;
                        o_res.ack_wanted = end_c[1];
                        o_res.frame_over = (end_c == zdsr_pkg::END_ZCRCE);
                        n_crc    = zdsr_pkg::CRC_PRESET;
                        n_in_crc = 1'b0;
                        n_cnt    = 2'd0;
                        n_rx_crc = 32'd0;
                    end
                end else if (i_tok.is_end) begin
                    n_crc    = zdsr_pkg::crc_add(crc_c, i_tok.value ^ zdsr_pkg::ESC_XOR);
                    n_end    = zdsr_pkg::t_end'(i_tok.value[1:0]);
                    n_in_crc = 1'b1;
                    n_cnt    = 2'd0;
                    n_rx_crc = 32'd0;
                end else begin
                    n_crc      = zdsr_pkg::crc_add(crc_c, i_tok.value);
                    o_res_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= zdsr_pkg::CRC_PRESET;
            r_in_crc <= 1'b0;
            r_cnt    <= 2'd0;
            r_rx_crc <= 32'd0;
            r_end    <= zdsr_pkg::END_ZCRCE;
        end else begin
            r_crc    <= n_crc;
            r_in_crc <= n_in_crc;
            r_cnt    <= n_cnt;
            r_rx_crc <= n_rx_crc;
            r_end    <= n_end;
        end
    end

    a_cnt_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> r_in_crc)
        else $error("crc byte count set outside crc phase");

    a_verdict_presets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.kind != zdsr_pkg::KIND_DATA)
            |=> (r_crc == zdsr_pkg::CRC_PRESET && !r_in_crc && r_cnt == 2'd0))
        else $error("crc not preset after verdict");

    a_data_outside_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.kind == zdsr_pkg::KIND_DATA) |-> !phase_c && !i_tok.is_end)
        else $error("data item emitted inside crc phase");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (o_tok_pop && !i_res_full))
        else $error("result pushed without a popped item");

endmodule
